@@ rtl/ktgd_pkg.sv @@
// Key tap gesture detector package: event entry, gesture flag and
// register index types shared by the detector modules.
// No dependencies.
package ktgd_pkg;

   localparam int unsigned CODE_W   = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned WINDOW_W = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [WINDOW_W-1:0] TAP_WINDOW_RESET    = 16'd250;
   localparam logic [WINDOW_W-1:0] DOUBLE_WINDOW_RESET = 16'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_WINDOW    = 1'b0,
      CSR_DOUBLE_WINDOW = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              press;
      logic [TIME_W-1:0] stamp;
   } event_type;

   typedef struct packed {
      logic tapped;
      logic tap_held;
      logic double_tapped;
   } gesture_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] tap_window;
      logic [WINDOW_W-1:0] double_window;
   } window_type;

endpackage

@@ rtl/ktgd_eval.sv @@
// Gesture evaluation: compares the new event against the three previous
// events and the configured windows. Depends on ktgd_pkg.
module ktgd_eval (
   input  ktgd_pkg::event_type   new_event,
   input  ktgd_pkg::event_type   prev1,
   input  ktgd_pkg::event_type   prev2,
   input  ktgd_pkg::event_type   prev3,
   input  logic [1:0]            prev_count,
   input  ktgd_pkg::window_type  windows,
   output ktgd_pkg::gesture_type gesture
);

   logic [ktgd_pkg::TIME_W-1:0] diff1;
   logic [ktgd_pkg::TIME_W-1:0] diff2;
   logic [ktgd_pkg::TIME_W-1:0] diff3;
   logic [ktgd_pkg::TIME_W-1:0] tap_limit;
   logic [ktgd_pkg::TIME_W-1:0] double_limit;
   logic                        p1_press;
   logic                        p1_release;
   logic                        p2_press;
   logic                        p2_release;
   logic                        p3_press;
   logic                        tap_hit;

   assign diff1 = new_event.stamp - prev1.stamp;
   assign diff2 = new_event.stamp - prev2.stamp;
   assign diff3 = new_event.stamp - prev3.stamp;

   assign tap_limit    = {{(ktgd_pkg::TIME_W-ktgd_pkg::WINDOW_W){1'b0}}, windows.tap_window};
   assign double_limit = {{(ktgd_pkg::TIME_W-ktgd_pkg::WINDOW_W){1'b0}},
                          windows.double_window};

   assign p1_press   = (prev1.code == new_event.code) && prev1.press;
   assign p1_release = (prev1.code == new_event.code) && !prev1.press;
   assign p2_press   = (prev2.code == new_event.code) && prev2.press;
   assign p2_release = (prev2.code == new_event.code) && !prev2.press;
   assign p3_press   = (prev3.code == new_event.code) && prev3.press;

   assign tap_hit = (prev_count >= 2'd1) && p1_press && !new_event.press
                    && (diff1 < tap_limit);

   assign gesture.tapped        = tap_hit;
   assign gesture.tap_held      = (prev_count >= 2'd2) && p2_press && p1_release
                                  && new_event.press && (diff2 < double_limit);
   assign gesture.double_tapped = (prev_count == 2'd3) && tap_hit && p3_press
                                  && p2_release && (diff3 < double_limit);

endmodule

@@ rtl/key_tap_gesture_detector.sv @@
// Key tap gesture detector top level: input register, event history,
// gesture evaluation and result register. Depends on ktgd_pkg, ktgd_eval.
// An accepted req beat passes the input register, then the result register, to rsp_valid.
// Throughput: one event per cycle while rsp is not stalled; a stalled rsp holds one beat
// in the result register while the input register takes the next.
// Reset clears beat valids and history count; windows return to 250/500 ms.
module key_tap_gesture_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ktgd_pkg::CODE_W-1:0]         req_key_code,
   input  logic                                req_is_press,
   input  logic [ktgd_pkg::TIME_W-1:0]         req_event_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_tapped,
   output logic                                rsp_tap_held,
   output logic                                rsp_double_tapped,
   input  logic                                csr_we,
   input  logic [ktgd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ktgd_pkg::WINDOW_W-1:0]       csr_wdata
);

   ktgd_pkg::window_type  windows_ff;
   ktgd_pkg::window_type  windows_in;
   logic                  in_valid_ff;
   ktgd_pkg::event_type   in_event_ff;
   ktgd_pkg::event_type   hist1_ff;
   ktgd_pkg::event_type   hist2_ff;
   ktgd_pkg::event_type   hist3_ff;
   logic [1:0]            hist_count_ff;
   logic [1:0]            hist_count_in;
   logic                  out_valid_ff;
   ktgd_pkg::gesture_type out_gesture_ff;
   ktgd_pkg::gesture_type gesture;
   logic                  out_free;
   logic                  advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      windows_in = windows_ff;
      if (csr_we) begin
         unique case (ktgd_pkg::csr_index_type'(csr_index))
            ktgd_pkg::CSR_TAP_WINDOW:    windows_in.tap_window    = csr_wdata;
            ktgd_pkg::CSR_DOUBLE_WINDOW: windows_in.double_window = csr_wdata;
            default:                     windows_in = windows_ff;
         endcase
      end
   end

   assign hist_count_in = (hist_count_ff == 2'd3) ? hist_count_ff : hist_count_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         windows_ff.tap_window    <= ktgd_pkg::TAP_WINDOW_RESET;
         windows_ff.double_window <= ktgd_pkg::DOUBLE_WINDOW_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         hist_count_ff <= 2'd0;
      end else begin
         windows_ff <= windows_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            hist_count_ff <= hist_count_in;
         end
      end
   end

   // hold payload until the next beat is taken
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_event_ff.code  <= req_key_code;
         in_event_ff.press <= req_is_press;
         in_event_ff.stamp <= req_event_time;
      end
      if (advance) begin
         hist1_ff       <= in_event_ff;
         hist2_ff       <= hist1_ff;
         hist3_ff       <= hist2_ff;
         out_gesture_ff <= gesture;
      end
   end

   ktgd_eval u_eval (
      .new_event  (in_event_ff),
      .prev1      (hist1_ff),
      .prev2      (hist2_ff),
      .prev3      (hist3_ff),
      .prev_count (hist_count_ff),
      .windows    (windows_ff),
      .gesture    (gesture)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_tapped        = out_gesture_ff.tapped;
   assign rsp_tap_held      = out_gesture_ff.tap_held;
   assign rsp_double_tapped = out_gesture_ff.double_tapped;

endmodule

@@ rtl/ktgd_checker.sv @@
// Port-level checks for the key tap gesture detector, bound to the top
// level. Depends on key_tap_gesture_detector.
module ktgd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_tapped,
   input logic rsp_tap_held,
   input logic rsp_double_tapped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_tapped) && $stable(rsp_tap_held) && $stable(rsp_double_tapped))
      else $error("rsp payload changed while stalled");

   a_double_needs_tap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_double_tapped |-> rsp_tapped)
      else $error("double tap without tap");

   a_tap_held_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tapped && rsp_tap_held))
      else $error("tap and tap-held on one event");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

bind key_tap_gesture_detector ktgd_checker u_ktgd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_tapped        (rsp_tapped),
   .rsp_tap_held      (rsp_tap_held),
   .rsp_double_tapped (rsp_double_tapped)
);
